// ----- hdl/scdl_pkg.sv -----
package scdl_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_TRIP_THRESHOLD     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TRIP_DELAY         = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RECOVER_DELAY      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LATCH_LIMIT        = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LATCH_DECAY_DELAY  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_LATCH_RECOVER_TIME = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_LATCH_RECOVER_LVL  = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_LATCH_CUR_RECOV_ON = 3'd7;

  // Register reset values
  localparam logic [7:0]         RST_TRIP_THRESHOLD     = 8'd100;
  localparam logic [7:0]         RST_TRIP_DELAY         = 8'd2;
  localparam logic [7:0]         RST_RECOVER_DELAY      = 8'd2;
  localparam logic [7:0]         RST_LATCH_LIMIT        = 8'd3;
  localparam logic [7:0]         RST_LATCH_DECAY_DELAY  = 8'd100;
  localparam logic [7:0]         RST_LATCH_RECOVER_TIME = 8'd150;
  localparam logic signed [15:0] RST_LATCH_RECOVER_LVL  = -16'sd10;
  localparam logic               RST_LATCH_CUR_RECOV_ON = 1'b0;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ALERT  = 2'd1,
    MODE_TRIP   = 2'd2
  } mode_t;

  typedef struct packed {
    logic [7:0]         trip_threshold;
    logic [7:0]         trip_delay;
    logic [7:0]         recover_delay;
    logic [7:0]         latch_limit;
    logic [7:0]         latch_decay_delay;
    logic [7:0]         latch_recover_time;
    logic signed [15:0] latch_recover_level;
    logic               latch_current_recovery_on;
  } cfg_t;

  typedef struct packed {
    mode_t      sc_mode;
    logic [7:0] sc_trip_count;
    logic [7:0] sc_recover_count;
    mode_t      latch_mode;
    logic [7:0] latch_event_count;
    logic [7:0] latch_idle_count;
    logic [7:0] latch_recover_count;
  } state_t;

  typedef struct packed {
    logic sc_alert;
    logic sc_fault;
    logic latch_warn;
    logic latch_fault;
  } flags_t;

  // A limit of zero never hits; any other limit hits when the count equals the limit minus one
  function automatic logic count_hits(input logic [7:0] count, input logic [7:0] limit);
    count_hits = (limit != 8'd0) && (count == (limit - 8'd1));
  endfunction

endpackage

// ----- hdl/short_circuit_discharge_latch.sv -----
// Discharge short-circuit protection with a trip-counting latch. Each input beat carries one
// signed current sample and the load-detect bit; each produces exactly one output beat with the
// alert and fault flags of both machines as they stood before that sample was applied. A beat
// waits in the input register, then the state update and the flag result are formed in a
// single pass and written to the output register, so one sample is taken every clock while the
// output side is ready. Write configuration only while the block holds no beat.
module short_circuit_discharge_latch (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [23:0]                         s_tdata,   // current_sample[15:0], load_present
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [7:0]                          m_tdata,   // sc_alert, sc_fault, latch_warn,
                                                         // latch_fault
  input  logic                                cfg_we,
  input  logic [scdl_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [scdl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  scdl_pkg::cfg_t    cfg;
  scdl_pkg::state_t  state;
  scdl_pkg::state_t  state_next;
  scdl_pkg::flags_t  flags;

  logic               in_valid;
  logic signed [15:0] in_sample;
  logic               in_load;
  logic               out_valid;
  logic [3:0]         out_flags;
  logic               advance;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = {4'd0, out_flags};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trip_threshold            <= scdl_pkg::RST_TRIP_THRESHOLD;
      cfg.trip_delay                <= scdl_pkg::RST_TRIP_DELAY;
      cfg.recover_delay             <= scdl_pkg::RST_RECOVER_DELAY;
      cfg.latch_limit               <= scdl_pkg::RST_LATCH_LIMIT;
      cfg.latch_decay_delay         <= scdl_pkg::RST_LATCH_DECAY_DELAY;
      cfg.latch_recover_time        <= scdl_pkg::RST_LATCH_RECOVER_TIME;
      cfg.latch_recover_level       <= scdl_pkg::RST_LATCH_RECOVER_LVL;
      cfg.latch_current_recovery_on <= scdl_pkg::RST_LATCH_CUR_RECOV_ON;
    end else if (cfg_we) begin
      case (cfg_index)
        scdl_pkg::REG_TRIP_THRESHOLD:     cfg.trip_threshold      <= cfg_wdata[7:0];
        scdl_pkg::REG_TRIP_DELAY:         cfg.trip_delay          <= cfg_wdata[7:0];
        scdl_pkg::REG_RECOVER_DELAY:      cfg.recover_delay       <= cfg_wdata[7:0];
        scdl_pkg::REG_LATCH_LIMIT:        cfg.latch_limit         <= cfg_wdata[7:0];
        scdl_pkg::REG_LATCH_DECAY_DELAY:  cfg.latch_decay_delay   <= cfg_wdata[7:0];
        scdl_pkg::REG_LATCH_RECOVER_TIME: cfg.latch_recover_time  <= cfg_wdata[7:0];
        scdl_pkg::REG_LATCH_RECOVER_LVL:  cfg.latch_recover_level <= $signed(cfg_wdata);
        scdl_pkg::REG_LATCH_CUR_RECOV_ON: cfg.latch_current_recovery_on <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_sample <= $signed(s_tdata[15:0]);
      in_load   <= s_tdata[16];
    end
  end

  scdl_step u_step (
    .cfg            (cfg),
    .cur            (state),
    .current_sample (in_sample),
    .load_present   (in_load),
    .nxt            (state_next),
    .flags          (flags)
  );

  // Commit the step only when its result beat moves into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state.sc_mode             <= scdl_pkg::MODE_NORMAL;
      state.sc_trip_count       <= 8'd0;
      state.sc_recover_count    <= 8'd0;
      state.latch_mode          <= scdl_pkg::MODE_NORMAL;
      state.latch_event_count   <= 8'd0;
      state.latch_idle_count    <= 8'd0;
      state.latch_recover_count <= 8'd0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_flags <= {flags.latch_fault, flags.latch_warn, flags.sc_fault, flags.sc_alert};
    end
  end

endmodule

// ----- hdl/scdl_step.sv -----
module scdl_step (
  input  scdl_pkg::cfg_t      cfg,
  input  scdl_pkg::state_t    cur,
  input  logic signed [15:0]  current_sample,
  input  logic                load_present,
  output scdl_pkg::state_t    nxt,
  output scdl_pkg::flags_t    flags
);

  logic signed [16:0] sample_ext;
  logic signed [16:0] trip_level;
  logic               safe;
  logic               above;

  assign sample_ext = {current_sample[15], current_sample};
  assign trip_level = -$signed({9'd0, cfg.trip_threshold});
  assign safe       = sample_ext >= trip_level;
  assign above      = current_sample >= cfg.latch_recover_level;

  // Short-circuit machine first, then the latch machine on the updated counts
  always_comb begin
    nxt = cur;
    case (cur.sc_mode)
      scdl_pkg::MODE_NORMAL: begin
        if (!safe) begin
          nxt.sc_trip_count = cur.sc_trip_count + 8'd1;
          nxt.sc_mode       = scdl_pkg::MODE_ALERT;
        end else if (cur.latch_event_count != 8'd0) begin
          nxt.latch_idle_count = cur.latch_idle_count + 8'd1;
        end
      end
      scdl_pkg::MODE_ALERT: begin
        if (scdl_pkg::count_hits(cur.sc_trip_count, cfg.trip_delay) && !safe) begin
          nxt.sc_trip_count = 8'd0;
          nxt.sc_mode       = scdl_pkg::MODE_TRIP;
          if (cur.latch_mode != scdl_pkg::MODE_TRIP) begin
            nxt.latch_event_count = cur.latch_event_count + 8'd1;
          end
        end else if (safe) begin
          nxt.sc_trip_count = 8'd0;
          nxt.sc_mode       = scdl_pkg::MODE_NORMAL;
        end else begin
          nxt.sc_trip_count = cur.sc_trip_count + 8'd1;
        end
      end
      default: begin
        if (scdl_pkg::count_hits(cur.sc_recover_count, cfg.recover_delay) && safe) begin
          nxt.sc_recover_count = 8'd0;
          nxt.latch_idle_count = 8'd0;
          nxt.sc_mode          = scdl_pkg::MODE_NORMAL;
        end else if (safe) begin
          nxt.sc_recover_count = cur.sc_recover_count + 8'd1;
        end else begin
          nxt.sc_recover_count = 8'd0;
        end
      end
    endcase

    case (cur.latch_mode)
      scdl_pkg::MODE_NORMAL: begin
        if (nxt.latch_event_count != 8'd0) begin
          nxt.latch_mode = scdl_pkg::MODE_ALERT;
        end
      end
      scdl_pkg::MODE_ALERT: begin
        if (nxt.latch_event_count == cfg.latch_limit) begin
          nxt.latch_event_count = 8'd0;
          nxt.latch_mode        = scdl_pkg::MODE_TRIP;
        end else if (nxt.latch_event_count == 8'd0) begin
          nxt.latch_mode = scdl_pkg::MODE_NORMAL;
        end else if (nxt.latch_idle_count >= cfg.latch_decay_delay) begin
          nxt.latch_event_count = nxt.latch_event_count - 8'd1;
        end
      end
      default: begin
        if (!load_present) begin
          nxt.latch_recover_count = 8'd0;
          nxt.latch_mode          = scdl_pkg::MODE_NORMAL;
        end else if (cfg.latch_current_recovery_on && above &&
                     scdl_pkg::count_hits(cur.latch_recover_count, cfg.latch_recover_time)) begin
          nxt.latch_recover_count = 8'd0;
          nxt.latch_mode          = scdl_pkg::MODE_NORMAL;
        end else if (cfg.latch_current_recovery_on && above) begin
          nxt.latch_recover_count = cur.latch_recover_count + 8'd1;
        end else begin
          nxt.latch_recover_count = 8'd0;
        end
      end
    endcase
  end

  // Report the modes held on entry
  always_comb begin
    flags.sc_alert    = (cur.sc_mode == scdl_pkg::MODE_ALERT);
    flags.sc_fault    = (cur.sc_mode == scdl_pkg::MODE_TRIP);
    flags.latch_warn  = (cur.latch_mode == scdl_pkg::MODE_ALERT);
    flags.latch_fault = (cur.latch_mode == scdl_pkg::MODE_TRIP);
  end

endmodule
